// ----- rtl/core/lss_pkg.sv -----
// ----------------------------------------------------------------------------
// Linear sweep sine generator package
// Widths, register indexes and the quarter-wave sine table shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

	localparam int PHASE_BITS     = 32;
	localparam int SINE_ADDR_BITS = 10;
	localparam int QTR_BITS       = SINE_ADDR_BITS - 2;
	localparam int QUARTER        = 1 << QTR_BITS;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;
	localparam int MAG_BITS       = 15;
	localparam int AMP_BITS       = 15;
	localparam int SAMPLE_BITS    = 16;
	localparam int PROD_BITS      = MAG_BITS + AMP_BITS;

	typedef logic [PHASE_BITS-1:0] phase_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_START_INCREMENT = 2'd0,
		REG_SWEEP_STEP      = 2'd1,
		REG_AMPLITUDE       = 2'd2
	} cfg_reg_t;

	// Side information that travels with a table read.
	typedef struct packed {
		logic negative; // lower half of the turn
		logic peak;     // exactly a quarter turn past the mirror point
	} tag_t;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

	// sin(j * (pi/2) / QUARTER) as a Q1.15 magnitude, Horner form of the
	// degree-13 odd Taylor series in unsigned Q30, rounded half up.
	function automatic logic [MAG_BITS-1:0] quarter_sine(input int unsigned j);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] term;
		logic [63:0] s;
		logic [63:0] v;
		x    = (64'(j) * HALF_PI_Q30) >> QTR_BITS;
		x2   = (x * x) >> 30;
		t    = Q30_ONE;
		term = ((x2 * t) >> 30) / 64'd156;
		t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
		term = ((x2 * t) >> 30) / 64'd110;
		t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
		term = ((x2 * t) >> 30) / 64'd72;
		t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
		term = ((x2 * t) >> 30) / 64'd42;
		t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
		term = ((x2 * t) >> 30) / 64'd20;
		t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
		term = ((x2 * t) >> 30) / 64'd6;
		t    = (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
		s    = (x * t) >> 30;
		v    = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
		return (v > 64'd32767) ? {MAG_BITS{1'b1}} : v[MAG_BITS-1:0];
	endfunction

	typedef logic [QUARTER-1:0][MAG_BITS-1:0] qtab_t;

	function automatic qtab_t build_quarter();
		qtab_t tab;
		for (int k = 0; k < QUARTER; k++) begin
			tab[k] = quarter_sine(k);
		end
		return tab;
	endfunction

	localparam qtab_t QUARTER_TABLE = build_quarter();

	// Value at exactly a quarter turn, which the table itself does not hold.
	localparam logic [MAG_BITS-1:0] QUARTER_PEAK = quarter_sine(QUARTER);

	// Sign extend (or truncate) a 32-bit register to the phase width.
	function automatic phase_t widen_step(input logic [CFG_DATA_BITS-1:0] v);
		return phase_t'(signed'(v));
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/linear_sweep_sine_generator.sv -----
// ----------------------------------------------------------------------------
// Linear sweep sine generator
// Chirp source by direct digital synthesis: one stereo frame per tick.
// ----------------------------------------------------------------------------
// Usage
//   tick channel  : one beat per sample; restart_sweep reloads the running
//                   increment from start_increment before that sample.
//   frame channel : one beat per tick, left_sample == right_sample ==
//                   sine(phase) * amplitude / 32768, truncated toward zero.
//   cfg channel   : cfg_index selects start_increment (0), sweep_step (1) or
//                   amplitude (2); other indexes are dropped. Always ready.
//                   Write only while no frame is outstanding.
//   Throughput    : one tick per cycle unless the frames stall; the phase
//                   and increment adders close their loop unpipelined.
//   Pipeline      : a tick passes the quarter table RAM read, the amplitude
//                   multiply and the sign/output register on its way to its frame.
//   Reset         : phase, increment and registers clear; then the quarter
//                   wave table is loaded into RAM, one entry a cycle, for all
//                   QUARTER (256) entries with tick_ready low.
//   Stall         : a stalled frame holds in the output register; each stage
//                   keeps taking beats until the stage after it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_sweep_sine_generator import lss_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// tick channel
	input  wire logic                          tick_valid,
	output      logic                          tick_ready,
	input  wire logic                          restart_sweep,
	// frame channel
	output      logic                          frame_valid,
	input  wire logic                          frame_ready,
	output      logic signed [SAMPLE_BITS-1:0] left_sample,
	output      logic signed [SAMPLE_BITS-1:0] right_sample,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

	// Configuration registers
	logic [CFG_DATA_BITS-1:0] start_inc_q;
	logic [CFG_DATA_BITS-1:0] sweep_step_q;
	logic [AMP_BITS-1:0]      amplitude_q;

	// Oscillator state
	phase_t phase_q;
	phase_t inc_q;

	// Table load sweep: the top bit set means the RAM is loaded.
	logic [QTR_BITS:0] fill_cnt_q;
	logic              fill_done;

	// Pipeline
	logic                        valid_s1;
	tag_t                        tag_s1;
	logic                        valid_s2;
	logic                        neg_s2;
	logic [PROD_BITS-1:0]        prod_s2;
	logic                        frame_valid_q;
	logic [SAMPLE_BITS-1:0]      sample_q;

	logic en_out;
	logic en_s2;
	logic en_s1;
	logic tick_fire;

	phase_t                    inc_sel;
	phase_t                    inc_new;
	logic [SINE_ADDR_BITS-1:0] tab_addr;
	logic [1:0]                quad;
	logic [QTR_BITS-1:0]       ofs;
	logic [QTR_BITS-1:0]       ram_raddr;
	tag_t                      tag_new;
	logic [MAG_BITS-1:0]       ram_rdata;
	logic [MAG_BITS-1:0]       mag_s1;
	logic [MAG_BITS-1:0]       mag_out;
	logic [SAMPLE_BITS-1:0]    sample_new;

	assign fill_done = fill_cnt_q[QTR_BITS];

	// Each stage advances when the stage after it is empty or advancing.
	assign en_out     = !frame_valid_q || frame_ready;
	assign en_s2      = !valid_s2 || en_out;
	assign en_s1      = !valid_s1 || en_s2;
	assign tick_ready = fill_done && en_s1;
	assign tick_fire  = tick_valid && tick_ready;
	assign cfg_ready  = 1'b1;

	// Increment first takes the sweep step, then the phase takes the new increment.
	assign inc_sel = restart_sweep ? widen_step(start_inc_q) : inc_q;
	assign inc_new = inc_sel + widen_step(sweep_step_q);

	// Fold the top phase bits onto the quarter wave: odd quadrants mirror,
	// the lower half of the turn negates.
	assign tab_addr         = phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS];
	assign quad             = tab_addr[SINE_ADDR_BITS-1 -: 2];
	assign ofs              = tab_addr[QTR_BITS-1:0];
	assign ram_raddr        = quad[0] ? (~ofs + 1'b1) : ofs;
	assign tag_new.negative = quad[1];
	assign tag_new.peak     = quad[0] && (ofs == '0);

	lss_ram #(
		.WIDTH(MAG_BITS),
		.DEPTH(QUARTER)
	) u_quarter_ram (
		.clk   (clk),
		.we    (!fill_done),
		.waddr (fill_cnt_q[QTR_BITS-1:0]),
		.wdata (QUARTER_TABLE[fill_cnt_q[QTR_BITS-1:0]]),
		.re    (en_s1),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign mag_s1     = tag_s1.peak ? QUARTER_PEAK : ram_rdata;
	assign mag_out    = prod_s2[PROD_BITS-1 -: MAG_BITS];
	assign sample_new = neg_s2 ? (~{1'b0, mag_out} + 1'b1) : {1'b0, mag_out};

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_inc_q   <= '0;
			sweep_step_q  <= '0;
			amplitude_q   <= '0;
			phase_q       <= '0;
			inc_q         <= '0;
			fill_cnt_q    <= '0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			frame_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_START_INCREMENT: start_inc_q  <= cfg_data;
					REG_SWEEP_STEP:      sweep_step_q <= cfg_data;
					REG_AMPLITUDE:       amplitude_q  <= cfg_data[AMP_BITS-1:0];
					default: ;
				endcase
			end
			if (!fill_done) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end
			if (tick_fire) begin
				inc_q   <= inc_new;
				phase_q <= phase_q + inc_new;
			end
			if (en_s1) begin
				valid_s1 <= tick_fire;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				frame_valid_q <= valid_s2;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en_s1) begin
			tag_s1 <= tag_new;
		end
		if (en_s2) begin
			neg_s2  <= tag_s1.negative;
			prod_s2 <= PROD_BITS'(mag_s1) * PROD_BITS'(amplitude_q);
		end
		if (en_out) begin
			sample_q <= sample_new;
		end
	end

	assign frame_valid  = frame_valid_q;
	assign left_sample  = sample_q;
	assign right_sample = sample_q;

	// No tick may enter while the sine table is still loading.
	a_no_tick_while_loading: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_done |-> !tick_ready)
		else $error("tick taken before table load finished");

	// An accepted tick occupies the read stage on the next cycle.
	a_tick_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		tick_fire |=> valid_s1)
		else $error("accepted tick lost before read stage");

	// A product blocked by a full output register must hold.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !en_out |=> valid_s2 && $stable(prod_s2) && $stable(neg_s2))
		else $error("stalled product changed");

endmodule

`default_nettype wire

// ----- rtl/core/lss_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear sweep sine generator testbench
// Drives sample ticks and register writes into the chirp source, predicts
// each stereo frame from an independent fixed-point sine table and sweep
// model, and compares every frame leaving the block against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import lss_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int PACE_MAX       = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAND_PHASES    = 24;
	localparam int LUT_SIZE       = 1 << SINE_ADDR_BITS;
	localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
	localparam logic [63:0] HALF_TURN_Q30 = 64'd1686629713; // pi/2 in Q30

	// Index past the last register: the block must drop this write.
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
	} frame_t;

	// ------------------------------------------------------------------
	// Clock, reset and block ports
	// ------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                          tick_valid    = 1'b0;
	logic                          tick_ready;
	logic                          restart_sweep = 1'b0;
	logic                          frame_valid;
	logic                          frame_ready   = 1'b0;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;
	logic                          cfg_valid     = 1'b0;
	logic                          cfg_ready;
	logic [CFG_INDEX_BITS-1:0]     cfg_index     = '0;
	logic [CFG_DATA_BITS-1:0]      cfg_data      = '0;

	always #(CLK_PERIOD/2) clk = ~clk;

	linear_sweep_sine_generator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.restart_sweep(restart_sweep),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------
	// Sweep model: registers, running phase and increment, sine table
	// ------------------------------------------------------------------
	phase_t                        start_word_q = '0;
	phase_t                        step_word_q  = '0;
	logic [AMP_BITS-1:0]           amp_q        = '0;
	phase_t                        tone_phase   = '0;
	phase_t                        tone_incr    = '0;
	logic signed [SAMPLE_BITS-1:0] sine_lut [LUT_SIZE];

	frame_t      frames_due [$];
	int unsigned ticks_sent  = 0;
	int unsigned frames_seen = 0;
	int unsigned fail_count  = 0;
	int unsigned idle_cycles = 0;
	int unsigned frame_hold  = 0;
	bit          pace_on     = 1'b1;

	// Quarter-wave magnitude in Q1.15: odd Taylor series to degree 13 in
	// unsigned Q30, evaluated innermost term first, rounded half up.
	function automatic int unsigned qwave_mag(input int unsigned j);
		int unsigned dv [6] = '{156, 110, 72, 42, 20, 6};
		logic [63:0] ang;
		logic [63:0] ang_sq;
		logic [63:0] acc;
		logic [63:0] part;
		logic [63:0] mag;
		ang    = (64'(j) * HALF_TURN_Q30) >> (SINE_ADDR_BITS - 2);
		ang_sq = (ang * ang) >> 30;
		acc    = UNIT_Q30;
		foreach (dv[i]) begin
			part = ((ang_sq * acc) >> 30) / 64'(dv[i]);
			acc  = (part >= UNIT_Q30) ? 64'd0 : UNIT_Q30 - part;
		end
		mag = ((((ang * acc) >> 30) * 64'd32767) + (UNIT_Q30 >> 1)) >> 30;
		return (mag > 64'd32767) ? 32'd32767 : mag[31:0];
	endfunction

	// Unfold the quarter wave into the full turn: mirror the odd quarters,
	// negate the lower half.
	function automatic void fill_lut();
		int unsigned quad;
		int unsigned off;
		int unsigned j;
		int          m;
		for (int k = 0; k < LUT_SIZE; k++) begin
			quad = k >> (SINE_ADDR_BITS - 2);
			off  = k & (QUARTER - 1);
			j    = quad[0] ? QUARTER - off : off;
			m    = int'(qwave_mag(j));
			sine_lut[k] = SAMPLE_BITS'(quad[1] ? -m : m);
		end
	endfunction

	function automatic void apply_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		unique case (idx)
			REG_START_INCREMENT: start_word_q = phase_t'(signed'(data));
			REG_SWEEP_STEP:      step_word_q  = phase_t'(signed'(data));
			REG_AMPLITUDE:       amp_q        = data[AMP_BITS-1:0];
			default: ; // drop writes to unknown indexes
		endcase
	endfunction

	// Form the frame for one tick, then advance increment and phase.
	function automatic void predict_frame(input logic restart);
		frame_t                    f;
		logic [SINE_ADDR_BITS-1:0] addr;
		int                        prod;
		int                        mag;
		if (restart)
			tone_incr = start_word_q;
		addr = tone_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
		prod = int'(sine_lut[addr]) * int'(amp_q);
		// truncate toward zero: shift the magnitude, restore the sign
		mag  = ((prod < 0) ? -prod : prod) >> 15;
		f.left  = SAMPLE_BITS'((prod < 0) ? -mag : mag);
		f.right = f.left;
		frames_due.push_back(f);
		tone_incr  = tone_incr + step_word_q;
		tone_phase = tone_phase + tone_incr;
	endfunction

	function automatic void check_frame();
		frame_t want;
		frames_seen++;
		if (frames_due.size() == 0) begin
			$error("frame with no tick pending: left_sample %0d right_sample %0d",
				left_sample, right_sample);
			fail_count++;
			return;
		end
		want = frames_due.pop_front();
		if (left_sample !== want.left) begin
			$error("left_sample: expected %0d, got %0d", want.left, left_sample);
			fail_count++;
		end
		if (right_sample !== want.right) begin
			$error("right_sample: expected %0d, got %0d", want.right, right_sample);
			fail_count++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: every handshake is sampled at the edge that completes it.
	// Register writes update the model first, then ticks are predicted,
	// then frames are checked, so one process owns all model state.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_reg_write(cfg_index, cfg_data);
			if (tick_valid && tick_ready)
				predict_frame(restart_sweep);
			if (frame_valid && frame_ready)
				check_frame();
			if ((cfg_valid && cfg_ready) || (tick_valid && tick_ready) ||
					(frame_valid && frame_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Abort when no beat moves on any channel for too long.
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Frame sink: after each accepted frame, hold ready low for a random
	// number of cycles (none while pacing is off).
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (frame_valid && frame_ready)
			frame_hold = pace_on ? $urandom_range(0, PACE_MAX) : 0;
		if (frame_hold != 0) begin
			frame_hold--;
			frame_ready <= 1'b0;
		end else begin
			frame_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Send one tick beat. Valid stays high after the beat so that a
	// back-to-back tick needs no drop; a gap drops it first.
	task automatic send_tick(input logic restart);
		int unsigned gap;
		gap = pace_on ? $urandom_range(0, PACE_MAX) : 0;
		if (gap != 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_valid    <= 1'b1;
		restart_sweep <= restart;
		@(posedge clk);
		while (!tick_ready) @(posedge clk);
		ticks_sent++;
	endtask

	// Drop tick valid and hold until every frame sent so far has come back.
	task automatic wait_drain();
		tick_valid <= 1'b0;
		while (frames_seen < ticks_sent) @(posedge clk);
	endtask

	// Write all three registers back to back, optionally followed by a
	// write to an unused index that must change nothing.
	task automatic program_regs(input logic [CFG_DATA_BITS-1:0] start_word,
			input logic [CFG_DATA_BITS-1:0] step_word,
			input logic [CFG_DATA_BITS-1:0] amp_word, input bit poke_unused);
		logic [CFG_INDEX_BITS-1:0] idx [4];
		logic [CFG_DATA_BITS-1:0]  val [4];
		int                        n;
		idx[0] = REG_START_INCREMENT; val[0] = start_word;
		idx[1] = REG_SWEEP_STEP;      val[1] = step_word;
		idx[2] = REG_AMPLITUDE;       val[2] = amp_word;
		idx[3] = REG_UNUSED;          val[3] = $urandom();
		n = poke_unused ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Register word: the extremes, fully random, or a small signed value.
	function automatic logic [CFG_DATA_BITS-1:0] pick_word();
		logic [CFG_DATA_BITS-1:0] small_val;
		small_val = $urandom_range(0, 65536);
		unique case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			4: return $urandom();
			default: return $urandom_range(0, 1) ? -small_val : small_val;
		endcase
	endfunction

	// Amplitude word: upper bits carry noise the block must ignore.
	function automatic logic [CFG_DATA_BITS-1:0] pick_amp();
		unique case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0000_7FFF;
			default: return $urandom();
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Registers at their reset value: amplitude zero, so silence.
	task automatic test_reset_defaults();
		send_tick(1'b0);
		send_tick(1'b1);
		wait_drain();
	endtask

	// A quarter turn per sample lands on zero, the peak, zero and the trough.
	task automatic test_quadrant_points();
		program_regs(32'h4000_0000, 32'h0000_0000, 32'h0000_7FFF, 1'b1);
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		wait_drain();
	endtask

	// Only the low 15 bits of the amplitude word count.
	task automatic test_amplitude_masking();
		program_regs(32'h8000_0000, 32'h0000_1000, 32'hFFFF_8000, 1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_drain();
		program_regs(32'h8000_0000, 32'h0000_1000, 32'hFFFF_FFFF, 1'b0);
		send_tick(1'b0);
		wait_drain();
	endtask

	// Drive the increment past both signed ends so it wraps.
	task automatic test_increment_wrap();
		program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_5A5A, 1'b0);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
		wait_drain();
		program_regs(32'h8000_0000, 32'h8000_0000, 32'h0000_2AAA, 1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_drain();
	endtask

	// A restart mid-sweep reloads the increment but keeps the phase.
	task automatic test_restart_keeps_phase();
		program_regs(32'h0100_0000, 32'h0040_0000, 32'h0000_7FFF, 1'b0);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);
		wait_drain();
	endtask

	// Steps just under one table entry: the low phase bits are truncated.
	task automatic test_sub_step_phase();
		program_regs(32'h003F_FFFF, 32'h0000_0000, 32'h0000_7FFF, 1'b0);
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		wait_drain();
	endtask

	// Random sweeps: each phase starts with a restart, restarts now and then,
	// and drains before the next register set. Every fourth phase runs
	// without idling on either side.
	task automatic test_random_sweeps();
		int unsigned n_items;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			pace_on = (ph % 4 != 3);
			program_regs(pick_word(), pick_word(), pick_amp(), $urandom_range(0, 1));
			n_items = $urandom_range(40, 80);
			for (int i = 0; i < n_items; i++)
				send_tick(i == 0 || $urandom_range(0, 19) == 0);
			// the sender pauses here until every frame has come back
			wait_drain();
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		fill_lut();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_quadrant_points();
		test_amplitude_masking();
		test_increment_wrap();
		test_restart_keeps_phase();
		test_sub_step_phase();
		test_random_sweeps();

		// Hold past the pipeline depth to catch stray frames.
		repeat (8) @(posedge clk);
		if (frames_due.size() != 0) begin
			$error("%0d frames expected but never seen", frames_due.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
